// ===== sv/bda_pkg.sv =====
package bda_pkg;

	localparam int unsigned ValueW    = 16;
	localparam int unsigned CharW     = 7;
	localparam int unsigned DigitW    = 4;
	localparam int unsigned NumDigits = 5;
	localparam int unsigned PosW      = 3;
	localparam int unsigned QueueDepthDefault = 2;

	localparam logic [CharW-1:0] CharZero  = 7'd48;
	localparam logic [CharW-1:0] CharComma = 7'd44;

	localparam logic [16:0] DivTenMul   = 17'd52429;
	localparam int unsigned DivTenShift = 19;
	localparam int unsigned ProdW       = ValueW + 17;

	localparam logic [PosW-1:0] UnitsPosInt    = PosW'(NumDigits - 1);
	localparam logic [PosW-1:0] UnitsPosTenths = PosW'(NumDigits - 2);
	localparam logic [PosW-1:0] CommaPos       = PosW'(NumDigits - 1);
	localparam logic [PosW-1:0] TenthsPos      = PosW'(NumDigits);

	typedef logic [DigitW-1:0] digit_t;

	typedef struct packed {
		digit_t [NumDigits-1:0] digits;
		logic                   tenths;
		logic [PosW-1:0]        first;
	} bda_entry_t;

endpackage

// ===== sv/bda_front.sv =====
module bda_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bda_pkg::ValueW-1:0]   value,
	input  logic                         tenths_mode,
	input  logic                         q_full,
	output logic                         q_push,
	output bda_pkg::bda_entry_t          q_entry
);
	import bda_pkg::*;

	localparam int unsigned CntW = $clog2(NumDigits);

	logic [ValueW-1:0]       rest_q;
	digit_t [NumDigits-1:0]  digits_q;
	logic [CntW-1:0]         cnt_q;
	logic                    active_q;
	logic                    tenths_q;

	logic [ProdW-1:0]        prod;
	logic [ValueW-1:0]       quot;
	logic [DigitW-1:0]       quot_x10;
	digit_t                  digit;
	digit_t [NumDigits-1:0]  digits_next;
	logic                    final_step;
	logic                    advance;
	logic [PosW-1:0]         first;
	logic [PosW-1:0]         units_pos;

	// Divide by ten through the reciprocal; exact for every 16-bit value.
	assign prod     = ProdW'(rest_q) * ProdW'(DivTenMul);
	assign quot     = ValueW'(prod >> DivTenShift);
	assign quot_x10 = DigitW'({quot[0], 3'b000}) + DigitW'({quot[2:0], 1'b0});
	assign digit    = rest_q[DigitW-1:0] - quot_x10;

	always_comb begin
		digits_next[0] = digit;
		for (int p = 1; p < NumDigits; p++) begin
			digits_next[p] = digits_q[p-1];
		end
	end

	assign final_step = active_q && (cnt_q == CntW'(NumDigits - 1));
	assign advance    = active_q && !(final_step && q_full);
	assign q_push     = final_step && !q_full;
	assign busy       = active_q;

	assign units_pos = tenths_q ? UnitsPosTenths : UnitsPosInt;

	always_comb begin
		first = units_pos;
		for (int p = NumDigits - 2; p >= 0; p--) begin
			if ((PosW'(p) < units_pos) && (digits_next[p] != '0)) begin
				first = PosW'(p);
			end
		end
	end

	assign q_entry.digits = digits_next;
	assign q_entry.tenths = tenths_q;
	assign q_entry.first  = first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start && !active_q) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (advance) begin
			if (final_step) begin
				active_q <= 1'b0;
			end
			cnt_q <= cnt_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start && !active_q) begin
			rest_q   <= value;
			tenths_q <= tenths_mode;
		end else if (advance) begin
			rest_q   <= quot;
			digits_q <= digits_next;
		end
	end

endmodule

// ===== sv/bda_queue.sv =====
module bda_queue #(
	parameter int unsigned Depth = bda_pkg::QueueDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bda_pkg::bda_entry_t  push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output bda_pkg::bda_entry_t  head
);
	import bda_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	bda_entry_t        slots_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count lost a transaction");

endmodule

// ===== sv/bda_back.sv =====
module bda_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  bda_pkg::bda_entry_t         q_head,
	output logic                        q_pop,
	output logic                        strobe,
	output logic [bda_pkg::CharW-1:0]   char_code,
	output logic                        last
);
	import bda_pkg::*;

	bda_entry_t        cur_q;
	logic [PosW-1:0]   pos_q;
	logic              active_q;
	logic              strobe_q;
	logic [CharW-1:0]  char_q;
	logic              last_q;

	logic              is_last;
	logic              is_comma;
	logic [PosW-1:0]   digit_pos;
	digit_t            cur_digit;
	logic [CharW-1:0]  cur_char;

	assign is_last   = cur_q.tenths ? (pos_q == TenthsPos) : (pos_q == UnitsPosInt);
	assign is_comma  = cur_q.tenths && (pos_q == CommaPos);
	assign digit_pos = (cur_q.tenths && (pos_q == TenthsPos)) ? UnitsPosInt : pos_q;
	assign cur_digit = cur_q.digits[digit_pos];
	assign cur_char  = is_comma ? CharComma : (CharZero + CharW'(cur_digit));

	assign q_pop = !q_empty && (!active_q || is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (q_pop) begin
				active_q <= 1'b1;
			end else if (active_q && is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
			pos_q <= q_head.first;
		end else if (active_q) begin
			pos_q <= pos_q + PosW'(1);
		end
		char_q <= cur_char;
		last_q <= is_last;
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) (strobe && !last) |=> strobe)
		else $error("characters of one number are not contiguous");
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && last) |-> char_code != CharComma)
		else $error("number ended on a comma");
	assert property (@(posedge clk) disable iff (!arst_n) active_q |-> pos_q <= TenthsPos)
		else $error("character position ran past the tenths digit");

endmodule

// ===== sv/binary_to_decimal_ascii.sv =====
// Converts a 16-bit unsigned value into decimal ASCII text, one number per transaction.
// Input: drive value and tenths_mode with start high; the transaction is taken at a
// rising edge where start is high and busy is low.
// Output: each character appears on char_code for exactly one cycle with strobe high;
// last marks the final character of a number. The receiver cannot stall the output.
// Leading zeros are dropped, inner zeros are kept, and the units digit always appears.
// With tenths_mode set the lowest digit follows a comma, so 1234 becomes "123,4".
// The front splits a value into digits with one division by ten per cycle, and holds the
// last digit while the queue is full; busy stays high until the number is pushed into the
// queue, and a new value is taken only once busy is low.
// A two-entry queue holds converted numbers while the back end streams out one
// character per cycle, so a number of up to six characters never slows the input.
// When the block is otherwise empty, the first character passes through the front's digit
// steps, a queue slot, the back end's number register and its output registers.
// Reset clears the front, the queue and the output strobe; no result is pending after it.
module binary_to_decimal_ascii #(
	parameter int unsigned QueueDepth = bda_pkg::QueueDepthDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bda_pkg::ValueW-1:0]   value,
	input  logic                         tenths_mode,
	output logic                         strobe,
	output logic [bda_pkg::CharW-1:0]    char_code,
	output logic                         last
);
	import bda_pkg::*;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	bda_entry_t  q_in;
	bda_entry_t  q_head;

	bda_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.tenths_mode (tenths_mode),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_in)
	);

	bda_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	bda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last)
	);

endmodule

// ===== test/bda_text_checker.sv =====
module bda_text_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [bda_pkg::ValueW-1:0]  value,
	input  logic                        tenths_mode,
	input  logic                        strobe,
	input  logic [bda_pkg::CharW-1:0]   char_code,
	input  logic                        last,
	output int                          fail_count,
	output int                          chars_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import bda_pkg::*;

	typedef struct packed {
		logic [CharW-1:0] code;
		logic             last;
	} ascii_char_t;

	ascii_char_t expected_chars[$];
	int n_fail = 0;
	int n_pending = 0;

	assign fail_count    = n_fail;
	assign chars_pending = n_pending;

	function automatic void predict_text(input logic [ValueW-1:0] number, input logic tenths);
		int unsigned weight[NumDigits];
		int unsigned rest;
		logic [DigitW-1:0] digits[NumDigits];
		logic [CharW-1:0] codes[$];
		int units_pos;
		bit shown;
		ascii_char_t c;
		weight = '{10000, 1000, 100, 10, 1};
		rest = number;
		shown = 1'b0;
		for (int i = 0; i < NumDigits; i++) begin
			digits[i] = DigitW'(rest / weight[i]);
			rest = rest % weight[i];
		end
		// The units digit moves up one place when the lowest digit is a fraction.
		units_pos = tenths ? NumDigits - 2 : NumDigits - 1;
		for (int i = 0; i <= units_pos; i++) begin
			if (digits[i] != 0 || i == units_pos)
				shown = 1'b1;
			if (shown)
				codes.push_back(CharZero + CharW'(digits[i]));
		end
		if (tenths) begin
			codes.push_back(CharComma);
			codes.push_back(CharZero + CharW'(digits[NumDigits-1]));
		end
		for (int i = 0; i < codes.size(); i++) begin
			c.code = codes[i];
			c.last = (i == codes.size() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		ascii_char_t exp_c;
		if (arst_n) begin
			if (strobe) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected character, actual char_code=%0d last=%0b",
						$time, char_code, last);
					n_fail++;
				end else begin
					exp_c = expected_chars.pop_front();
					if (char_code !== exp_c.code) begin
						$display("%0t: char_code mismatch, expected %0d, actual %0d",
							$time, exp_c.code, char_code);
						n_fail++;
					end
					if (last !== exp_c.last) begin
						$display("%0t: last mismatch, expected %0b, actual %0b",
							$time, exp_c.last, last);
						n_fail++;
					end
				end
			end
			if (start && !busy)
				predict_text(value, tenths_mode);
			n_pending = expected_chars.size();
		end
	end

endmodule

// ===== test/binary_to_decimal_ascii_tb.sv =====
module binary_to_decimal_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bda_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [ValueW-1:0] value = '0;
	logic              tenths_mode = 1'b0;
	logic              strobe;
	logic [CharW-1:0]  char_code;
	logic              last;
	int                fail_count;
	int                chars_pending;
	bit                idle_enable = 1'b1;

	always #5 clk = ~clk;

	binary_to_decimal_ascii u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.tenths_mode (tenths_mode),
		.strobe      (strobe),
		.char_code   (char_code),
		.last        (last)
	);

	bda_text_checker u_text_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.tenths_mode   (tenths_mode),
		.strobe        (strobe),
		.char_code     (char_code),
		.last          (last),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	task automatic send_number(input logic [ValueW-1:0] number, input logic tenths);
		start       <= 1'b1;
		value       <= number;
		tenths_mode <= tenths;
		do @(posedge clk); while (busy);
		if (idle_enable && $urandom_range(0, 99) < 11) begin
			start       <= 1'b0;
			value       <= ValueW'($urandom);
			tenths_mode <= 1'($urandom);
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic logic [ValueW-1:0] random_number();
		int unsigned n;
		case ($urandom_range(0, 3))
			0: n = $urandom_range(0, 65535);
			1: n = $urandom_range(0, 99);
			2: n = $urandom_range(0, 9999);
			default: begin
				// Sparse digits give plenty of inner zeros.
				n = 0;
				for (int i = 0; i < NumDigits; i++)
					n = n * 10 + (($urandom_range(0, 1) != 0) ?
						$urandom_range(0, (i == 0) ? 5 : 9) : 0);
			end
		endcase
		return ValueW'(n);
	endfunction

	initial begin
		logic [ValueW-1:0] directed[$];
		directed = '{16'd0, 16'd65535, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd105,
			16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd60005, 16'd32768,
			16'h5555, 16'hAAAA, 16'd50000, 16'd1234};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_number(directed[i], 1'b0);
			if (i < 12)
				send_number(directed[i], 1'b1);
		end
		for (int i = 0; i < 90; i++) begin
			idle_enable = !(i >= 40 && i < 80);
			send_number(random_number(), 1'($urandom));
		end
		start <= 1'b0;
		@(negedge clk);
		while (chars_pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("[binary_to_decimal_ascii] OK");
		else
			$display("[binary_to_decimal_ascii] ERROR");
		$finish;
	end

	initial begin
		#1ms;
		$display("[binary_to_decimal_ascii] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/bda_pkg.sv
sv/bda_front.sv
sv/bda_queue.sv
sv/bda_back.sv
sv/binary_to_decimal_ascii.sv
test/bda_text_checker.sv
test/binary_to_decimal_ascii_tb.sv
